// ===== design/slpc_pkg.sv =====
// ----------------------------------------------------------------------------
// Status LED pattern controller package
// Shared types, mode and command codes, register indexes and reset values.
// ----------------------------------------------------------------------------
package slpc_pkg;

	// Field widths of the item, state and configuration fields.
	localparam int TIME_WIDTH  = 32;
	localparam int COUNT_WIDTH = 16;
	localparam int HALF_WIDTH  = 16;
	localparam int TOTAL_WIDTH = 8;

	// Configuration port.
	localparam int CFG_INDEX_WIDTH = 3;
	localparam int CFG_DATA_WIDTH  = 16;

	localparam logic [CFG_INDEX_WIDTH-1:0] CFG_DISC_HALF  = 3'd0;
	localparam logic [CFG_INDEX_WIDTH-1:0] CFG_RECON_HALF = 3'd1;
	localparam logic [CFG_INDEX_WIDTH-1:0] CFG_CONN_HALF  = 3'd2;
	localparam logic [CFG_INDEX_WIDTH-1:0] CFG_CONN_TOTAL = 3'd3;
	localparam logic [CFG_INDEX_WIDTH-1:0] CFG_ERR_HALF   = 3'd4;

	localparam logic [HALF_WIDTH-1:0]  DISC_HALF_RESET  = 16'd500;
	localparam logic [HALF_WIDTH-1:0]  RECON_HALF_RESET = 16'd300;
	localparam logic [HALF_WIDTH-1:0]  CONN_HALF_RESET  = 16'd100;
	localparam logic [TOTAL_WIDTH-1:0] CONN_TOTAL_RESET = 8'd6;
	localparam logic [HALF_WIDTH-1:0]  ERR_HALF_RESET   = 16'd500;

	// Item kinds.
	localparam logic CMD_UPDATE = 1'b0;
	localparam logic CMD_SET    = 1'b1;

	typedef enum logic [1:0] {
		MODE_DISCONNECTED = 2'd0,
		MODE_RECONNECTING = 2'd1,
		MODE_CONNECTED    = 2'd2,
		MODE_NORMAL       = 2'd3
	} mode_t;

	typedef struct packed {
		logic [HALF_WIDTH-1:0]  disc_half;
		logic [HALF_WIDTH-1:0]  recon_half;
		logic [HALF_WIDTH-1:0]  conn_half;
		logic [TOTAL_WIDTH-1:0] conn_total;
		logic [HALF_WIDTH-1:0]  err_half;
	} cfg_t;

	typedef struct packed {
		logic                   command;
		logic [TIME_WIDTH-1:0]  now_ms;
		logic [1:0]             new_mode;
		logic [COUNT_WIDTH-1:0] count_up;
		logic [COUNT_WIDTH-1:0] count_down;
		logic                   error_flag;
		logic                   stale_flag;
	} item_t;

	typedef struct packed {
		mode_t                  mode;
		logic                   conn_phase;
		logic [TIME_WIDTH-1:0]  conn_last;
		logic [TOTAL_WIDTH-1:0] conn_toggles;
		logic                   err_phase;
		logic [TIME_WIDTH-1:0]  err_last;
		logic                   led_red;
		logic                   led_green;
	} state_t;

endpackage

// ===== design/slpc_cfg.sv =====
// ----------------------------------------------------------------------------
// Status LED configuration registers
// Holds the blink half periods and the connected toggle total.
// ----------------------------------------------------------------------------
module slpc_cfg
	import slpc_pkg::*;
(
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       wr_en,
	input  logic [CFG_INDEX_WIDTH-1:0] wr_index,
	input  logic [CFG_DATA_WIDTH-1:0]  wr_data,
	output cfg_t                       cfg
);

	cfg_t cfg_q;

	// Register write; an unknown index is ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.disc_half  <= DISC_HALF_RESET;
			cfg_q.recon_half <= RECON_HALF_RESET;
			cfg_q.conn_half  <= CONN_HALF_RESET;
			cfg_q.conn_total <= CONN_TOTAL_RESET;
			cfg_q.err_half   <= ERR_HALF_RESET;
		end else if (wr_en) begin
			case (wr_index)
				CFG_DISC_HALF:  cfg_q.disc_half  <= wr_data;
				CFG_RECON_HALF: cfg_q.recon_half <= wr_data;
				CFG_CONN_HALF:  cfg_q.conn_half  <= wr_data;
				CFG_CONN_TOTAL: cfg_q.conn_total <= wr_data[TOTAL_WIDTH-1:0];
				CFG_ERR_HALF:   cfg_q.err_half   <= wr_data;
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ===== design/slpc_step.sv =====
// ----------------------------------------------------------------------------
// Status LED step logic
// Computes the next controller state for one item from the current state.
// ----------------------------------------------------------------------------
module slpc_step
	import slpc_pkg::*;
(
	input  cfg_t   cfg,
	input  item_t  item,
	input  state_t cur,
	output state_t nxt
);

	logic [TIME_WIDTH-1:0] conn_elapsed;
	logic [TIME_WIDTH-1:0] err_elapsed;
	logic                  go_normal;
	logic                  err_any;

	// Wrapping elapsed times since the last toggles.
	assign conn_elapsed = item.now_ms - cur.conn_last;
	assign err_elapsed  = item.now_ms - cur.err_last;
	assign err_any      = item.error_flag | item.stale_flag;

	always_comb begin
		nxt       = cur;
		go_normal = 1'b0;
		if (item.command == CMD_SET) begin
			// A mode change clears the connection blink state.
			if (mode_t'(item.new_mode) != cur.mode) begin
				nxt.mode         = mode_t'(item.new_mode);
				nxt.conn_toggles = '0;
				nxt.conn_phase   = 1'b0;
				nxt.conn_last    = '0;
			end
		end else begin
			case (cur.mode)
				MODE_DISCONNECTED: begin
					if (conn_elapsed >= TIME_WIDTH'(cfg.disc_half)) begin
						nxt.conn_phase = ~cur.conn_phase;
						nxt.led_red    = ~cur.conn_phase;
						nxt.led_green  = 1'b0;
						nxt.conn_last  = item.now_ms;
					end
				end
				MODE_RECONNECTING: begin
					if (conn_elapsed >= TIME_WIDTH'(cfg.recon_half)) begin
						nxt.conn_phase = ~cur.conn_phase;
						nxt.led_red    = ~cur.conn_phase;
						nxt.led_green  = ~cur.conn_phase;
						nxt.conn_last  = item.now_ms;
					end
				end
				MODE_CONNECTED: begin
					if (cur.conn_toggles < cfg.conn_total) begin
						if (conn_elapsed >= TIME_WIDTH'(cfg.conn_half)) begin
							nxt.conn_phase   = ~cur.conn_phase;
							nxt.led_red      = 1'b0;
							nxt.led_green    = ~cur.conn_phase;
							nxt.conn_last    = item.now_ms;
							nxt.conn_toggles = cur.conn_toggles + 1'b1;
						end
					end else begin
						// Green burst done: drop into normal mode in this update.
						nxt.mode         = MODE_NORMAL;
						nxt.conn_toggles = '0;
						nxt.conn_phase   = 1'b0;
						nxt.conn_last    = '0;
						go_normal        = 1'b1;
					end
				end
				default: begin
					go_normal = 1'b1;
				end
			endcase

			// Normal mode: error blink or majority colour.
			if (go_normal) begin
				if (err_any) begin
					if (err_elapsed > TIME_WIDTH'(cfg.err_half)) begin
						nxt.err_phase = ~cur.err_phase;
						nxt.err_last  = item.now_ms;
					end
					nxt.led_red   = nxt.err_phase;
					nxt.led_green = nxt.err_phase;
				end else begin
					nxt.led_green = item.count_up > item.count_down;
					nxt.led_red   = item.count_down > item.count_up;
				end
			end
		end
	end

endmodule

// ===== design/status_led_pattern_controller.sv =====
// ----------------------------------------------------------------------------
// Status LED pattern controller
// Drives an RGB status LED from connection mode items and market data updates.
// ----------------------------------------------------------------------------
// Usage:
// Items enter on the s_ channel. s_tuser is the item kind (0 update, 1 set
// mode); s_tdata carries the time stamp, new mode, up and down counts and the
// error and stale flags. Each item gives exactly one result on the m_ channel:
// the red, green and blue LED bits and the mode after the item.
// Configuration registers are written on the cfg_ channel; cfg_ready is always
// high. The user must write them only while no item is in flight; the block
// itself does not enforce it. An accepted item is held in the input register
// until the output register is free or emptying; the step logic then updates
// the controller state and loads the output register, which puts its result
// on the m_ channel. One item is taken per cycle while the receiver does not
// stall.
// When the receiver stalls, the output register holds its result and the
// input register fills; s_tready then drops until the result is taken.
// Reset puts the block in normal mode with the LED off and the registers at
// their default half periods (500, 300, 100 ms, 6 toggles, 500 ms).
// ----------------------------------------------------------------------------
module status_led_pattern_controller
	import slpc_pkg::*;
(
	input  logic                       clk,
	input  logic                       arst_n,
	// Item input.
	input  logic                       s_tvalid,
	output logic                       s_tready,
	// now_ms[31:0], new_mode[33:32], count_up[49:34], count_down[65:50],
	// error_flag[66], stale_flag[67], zero fill [71:68].
	input  logic [71:0]                s_tdata,
	// command[0].
	input  logic                       s_tuser,
	// Result output.
	output logic                       m_tvalid,
	input  logic                       m_tready,
	// led_red[0], led_green[1], led_blue[2], mode_now[4:3], zero fill [7:5].
	output logic [7:0]                 m_tdata,
	// Configuration writes.
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [CFG_INDEX_WIDTH-1:0] cfg_index,
	input  logic [CFG_DATA_WIDTH-1:0]  cfg_data
);

	cfg_t   cfg;
	item_t  item_s1;
	logic   valid_s1;
	logic   advance;
	state_t state_q;
	state_t state_next;
	logic   out_valid_s2;
	logic   led_red_s2;
	logic   led_green_s2;
	mode_t  mode_s2;

	assign cfg_ready = 1'b1;

	slpc_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	// The input register moves on when the output register is free or emptying.
	assign advance  = valid_s1 && (!out_valid_s2 || m_tready);
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	// Input payload register.
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			item_s1.command    <= s_tuser;
			item_s1.now_ms     <= s_tdata[31:0];
			item_s1.new_mode   <= s_tdata[33:32];
			item_s1.count_up   <= s_tdata[49:34];
			item_s1.count_down <= s_tdata[65:50];
			item_s1.error_flag <= s_tdata[66];
			item_s1.stale_flag <= s_tdata[67];
		end
	end

	slpc_step u_step (
		.cfg  (cfg),
		.item (item_s1),
		.cur  (state_q),
		.nxt  (state_next)
	);

	// Controller state, updated once per item.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.mode         <= MODE_NORMAL;
			state_q.conn_phase   <= 1'b0;
			state_q.conn_last    <= '0;
			state_q.conn_toggles <= '0;
			state_q.err_phase    <= 1'b0;
			state_q.err_last     <= '0;
			state_q.led_red      <= 1'b0;
			state_q.led_green    <= 1'b0;
		end else if (advance) begin
			state_q <= state_next;
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_s2 <= 1'b0;
		end else if (advance) begin
			out_valid_s2 <= 1'b1;
		end else if (m_tready) begin
			out_valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			led_red_s2   <= state_next.led_red;
			led_green_s2 <= state_next.led_green;
			mode_s2      <= state_next.mode;
		end
	end

	assign m_tvalid = out_valid_s2;
	assign m_tdata  = {3'b000, mode_s2, 1'b0, led_green_s2, led_red_s2};

	// A result on display matches the state left by its item.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[4:3] == state_q.mode && m_tdata[0] == state_q.led_red
			&& m_tdata[1] == state_q.led_green))
	else $error("result does not match controller state");

	// A set item leaves the block in the requested mode.
	assert property (@(posedge clk) disable iff (!arst_n)
		(advance && item_s1.command == CMD_SET) |=> (state_q.mode == $past(item_s1.new_mode)))
	else $error("set item did not reach its mode");

	// Any mode change clears the connection blink state.
	assert property (@(posedge clk) disable iff (!arst_n)
		(advance && state_next.mode != state_q.mode)
		|=> (state_q.conn_toggles == '0 && !state_q.conn_phase && state_q.conn_last == '0))
	else $error("mode change left connection blink state");

	// Every item that leaves the input register produces a result.
	assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> m_tvalid)
	else $error("item produced no result");

endmodule
